FILE: hdl/erc_pkg.sv
// Package for the elevator request controller: sequencer states and field widths.
// No dependencies.
package erc_pkg;

	localparam int FIELD_FLOOR_W = 4;
	localparam int TAG_W         = 16;
	localparam int CAP_W         = 5;
	localparam int COUNT_OUT_W   = 5;
	localparam int TOTAL_W       = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd8;

	localparam logic REQ_CALL = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_UNLD   = 7'b0000010,
		ST_UNLD_W = 7'b0000100,
		ST_BRD    = 7'b0001000,
		ST_BRD_W  = 7'b0010000,
		ST_MOVE   = 7'b0100000,
		ST_OUT    = 7'b1000000
	} seq_state_t;

endpackage

FILE: hdl/erc_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on erc_pkg.
interface erc_req_if;
	import erc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic [FIELD_FLOOR_W-1:0] from_floor;
	logic [FIELD_FLOOR_W-1:0] to_floor;
	logic [TAG_W-1:0]         passenger_id;
	modport source (output valid, req_type, from_floor, to_floor, passenger_id, input ready);
	modport sink   (input valid, req_type, from_floor, to_floor, passenger_id, output ready);
endinterface

interface erc_res_if;
	import erc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [FIELD_FLOOR_W-1:0] current_floor;
	logic                     idle;
	logic [COUNT_OUT_W-1:0]   boarded;
	logic [COUNT_OUT_W-1:0]   alighted;
	logic [TOTAL_W-1:0]       served_total;
	logic [TOTAL_W-1:0]       floors_total;
	logic                     call_dropped;
	modport source (output valid, current_floor, idle, boarded, alighted, served_total,
		floors_total, call_dropped, input ready);
	modport sink   (input valid, current_floor, idle, boarded, alighted, served_total,
		floors_total, call_dropped, output ready);
endinterface

interface erc_cfg_if;
	import erc_pkg::*;
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/erc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module erc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/elevator_request_controller.sv
// Top level of the elevator request controller.
// Depends on erc_pkg, erc_if and erc_ram.
//
// A call writes the queue tail, or is dropped when the queue is full, and
// shows its result. A tick walks the cabin list then the waiting queue,
// each entry in two steps (one for the RAM read, one to compact and write
// back), then makes its move step. The registered read of the queue and
// cabin RAMs sets this split. An idle tick goes straight to its result.
// The result register holds a finished result until taken. No clearing
// pass: entries are read only below counts.
module elevator_request_controller
	import erc_pkg::*;
#(
	parameter int FLOOR_COUNT = 16,
	parameter int QUEUE_DEPTH = 16,
	parameter int CABIN_SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	erc_req_if.sink   req,
	erc_res_if.source res,
	erc_cfg_if.sink   cfg
);
	localparam int FW  = (FLOOR_COUNT > 2) ? $clog2(FLOOR_COUNT) : 1;
	localparam int QA  = $clog2(QUEUE_DEPTH);
	localparam int QC  = $clog2(QUEUE_DEPTH + 1);
	localparam int CA  = (CABIN_SLOTS > 1) ? $clog2(CABIN_SLOTS) : 1;
	localparam int CC  = $clog2(CABIN_SLOTS + 1);
	localparam int QW  = 2 * FW + TAG_W;
	localparam int CW  = FW + TAG_W;
	localparam int LW  = (CC > CAP_W) ? CC : CAP_W;
	localparam logic [FW-1:0] TOP_FLOOR = FW'(FLOOR_COUNT - 1);

	seq_state_t state_q;
	logic [CAP_W-1:0] cap_q;
	logic [QC-1:0] wcount_q, wkeep_q, widx_q;
	logic [CC-1:0] ccount_q, ckeep_q, cidx_q;
	logic [FW-1:0] floor_q;
	logic [TOTAL_W-1:0] served_q, moves_q;
	logic [COUNT_OUT_W-1:0] brd_q, alt_q;
	logic drop_q, rvalid_q;

	// RAM ports
	logic q_we, c_we;
	logic [QA-1:0] q_wa, q_ra;
	logic [CA-1:0] c_wa, c_ra;
	logic [QW-1:0] q_wd, q_rd;
	logic [CW-1:0] c_wd, c_rd;

	erc_ram #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
	erc_ram #(.WIDTH(CW), .DEPTH(CABIN_SLOTS)) u_cabin (
		.clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));

	// Input floor saturation
	logic [FW-1:0] from_sat, to_sat;
	always_comb begin
		if (32'(req.from_floor) >= 32'(FLOOR_COUNT)) from_sat = TOP_FLOOR;
		else from_sat = FW'(req.from_floor);
		if (32'(req.to_floor) >= 32'(FLOOR_COUNT)) to_sat = TOP_FLOOR;
		else to_sat = FW'(req.to_floor);
	end

	logic req_take, full_q;
	assign req.ready = (state_q == ST_IDLE) && !rvalid_q;
	assign cfg.ready = 1'b1;
	assign req_take  = req.valid && req.ready;
	assign full_q    = (32'(wcount_q) >= 32'(QUEUE_DEPTH));

	logic [LW-1:0] limit;
	always_comb begin
		if (32'(cap_q) > 32'(CABIN_SLOTS)) limit = LW'(CABIN_SLOTS);
		else limit = LW'(cap_q);
	end

	// Fields of the entry just read
	logic [FW-1:0] rq_from, rq_to, rc_to;
	assign rq_from = q_rd[QW-1 -: FW];
	assign rq_to   = q_rd[TAG_W +: FW];
	assign rc_to   = c_rd[TAG_W +: FW];

	logic do_board;
	assign do_board = (rq_from == floor_q) && (LW'(ccount_q) < limit);

	// Memory port steering
	always_comb begin
		q_we = 1'b0; c_we = 1'b0;
		q_wa = wcount_q[QA-1:0];
		q_wd = {from_sat, to_sat, req.passenger_id};
		c_wa = ckeep_q[CA-1:0];
		c_wd = c_rd;
		q_ra = widx_q[QA-1:0];
		c_ra = cidx_q[CA-1:0];
		case (state_q)
			ST_IDLE: begin
				q_we = req_take && (req.req_type == REQ_CALL) && !full_q;
			end
			ST_UNLD_W: begin
				c_we = (rc_to != floor_q);
			end
			ST_BRD: begin
				// walk done: fetch both heads for the move step
				if (widx_q == wcount_q) begin
					q_ra = '0;
					c_ra = '0;
				end
			end
			ST_BRD_W: begin
				if (do_board) begin
					c_we = 1'b1;
					c_wa = ccount_q[CA-1:0];
					c_wd = q_rd[CW-1:0];
				end else begin
					q_we = 1'b1;
					q_wa = wkeep_q[QA-1:0];
					q_wd = q_rd;
				end
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cap_q    <= CAP_RESET;
			wcount_q <= '0; ccount_q <= '0;
			floor_q  <= '0; served_q <= '0; moves_q <= '0;
			rvalid_q <= 1'b0;
			wkeep_q <= '0; widx_q <= '0; ckeep_q <= '0; cidx_q <= '0;
			brd_q <= '0; alt_q <= '0; drop_q <= 1'b0;
		end else begin
			if (cfg.valid) cap_q <= cfg.data;
			if (rvalid_q && res.ready) rvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						brd_q <= '0; alt_q <= '0; drop_q <= 1'b0;
						cidx_q <= '0; ckeep_q <= '0; widx_q <= '0; wkeep_q <= '0;
						if (req.req_type == REQ_CALL) begin
							if (full_q) drop_q <= 1'b1;
							else wcount_q <= wcount_q + 1'b1;
							state_q <= ST_OUT;
						end else if (ccount_q == '0 && wcount_q == '0) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_UNLD;
						end
					end
				end
				ST_UNLD: begin
					if (cidx_q == ccount_q) begin
						ccount_q <= ckeep_q;
						state_q  <= ST_BRD;
					end else begin
						state_q <= ST_UNLD_W;
					end
				end
				ST_UNLD_W: begin
					if (rc_to != floor_q) ckeep_q <= ckeep_q + 1'b1;
					else begin
						alt_q    <= alt_q + 1'b1;
						served_q <= served_q + 1'b1;
					end
					cidx_q  <= cidx_q + 1'b1;
					state_q <= ST_UNLD;
				end
				ST_BRD: begin
					if (widx_q == wcount_q) begin
						wcount_q <= wkeep_q;
						cidx_q   <= '0;
						widx_q   <= '0;
						state_q  <= ST_MOVE;
					end else begin
						state_q <= ST_BRD_W;
					end
				end
				ST_BRD_W: begin
					if (do_board) begin
						ccount_q <= ccount_q + 1'b1;
						brd_q    <= brd_q + 1'b1;
					end else begin
						wkeep_q <= wkeep_q + 1'b1;
					end
					widx_q  <= widx_q + 1'b1;
					state_q <= ST_BRD;
				end
				ST_MOVE: begin
					// heads of both lists were read at index 0 last cycle
					state_q <= ST_OUT;
					if (ccount_q != '0) begin
						if (rc_to > floor_q) begin
							floor_q <= floor_q + 1'b1; moves_q <= moves_q + 1'b1;
						end else if (rc_to < floor_q) begin
							floor_q <= floor_q - 1'b1; moves_q <= moves_q + 1'b1;
						end
					end else if (wcount_q != '0) begin
						if (rq_from > floor_q) begin
							floor_q <= floor_q + 1'b1; moves_q <= moves_q + 1'b1;
						end else if (rq_from < floor_q) begin
							floor_q <= floor_q - 1'b1; moves_q <= moves_q + 1'b1;
						end
					end
				end
				ST_OUT: begin
					rvalid_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid         = rvalid_q;
	assign res.current_floor = FIELD_FLOOR_W'(floor_q);
	assign res.idle          = (ccount_q == '0) && (wcount_q == '0);
	assign res.boarded       = brd_q;
	assign res.alighted      = alt_q;
	assign res.served_total  = served_q;
	assign res.floors_total  = moves_q;
	assign res.call_dropped  = drop_q;
endmodule
